>>> rtl/u2rd_pkg.sv
// shared constants, types and helpers of the radix digit converter
package u2rd_pkg;

    localparam int VALUE_BITS     = 64;
    localparam int NUMBER_BITS    = 64;
    localparam int RADIX_BITS     = 6;
    localparam int CHAR_BITS      = 7;
    localparam int COUNT_BITS     = 7;
    localparam int STORE_DEPTH    = 64;
    localparam int ADDR_BITS      = $clog2(STORE_DEPTH);
    localparam int STEP_BITS      = 8;
    localparam int DIV_CHUNKS     = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int DIV_BITS       = DIV_CHUNKS * STEP_BITS;
    localparam int CHUNK_BITS     = (DIV_CHUNKS > 1) ? $clog2(DIV_CHUNKS) : 1;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RADIX_BITS-1:0] RADIX_MIN     = RADIX_BITS'(2);
    localparam logic [RADIX_BITS-1:0] RADIX_MAX     = RADIX_BITS'(36);
    localparam logic [RADIX_BITS-1:0] DECIMAL_LIMIT = RADIX_BITS'(10);
    localparam logic [CHAR_BITS-1:0]  CHAR_ZERO     = CHAR_BITS'(48);
    localparam logic [CHAR_BITS-1:0]  CHAR_LETTER_A = CHAR_BITS'(65);

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [RADIX_BITS-1:0] radix;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_pop;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_LOAD
    } t_back_state;

    function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [RADIX_BITS-1:0] rem);
        logic [CHAR_BITS-1:0] wide;
        wide = CHAR_BITS'(rem);
        if (rem < DECIMAL_LIMIT) begin
            return CHAR_ZERO + wide;
        end else begin
            return CHAR_LETTER_A + wide - CHAR_BITS'(DECIMAL_LIMIT);
        end
    endfunction

endpackage

>>> rtl/u2rd_if.sv
// word channels of the converter: request in, digit out
interface u2rd_in_if;
    logic                                valid;
    logic                                ready;
    logic [u2rd_pkg::NUMBER_BITS-1:0]    number;
    logic [u2rd_pkg::RADIX_BITS-1:0]     radix;

    modport source (output valid, output number, output radix, input ready);
    modport sink   (input valid, input number, input radix, output ready);
endinterface

interface u2rd_out_if;
    logic                                valid;
    logic                                ready;
    logic [u2rd_pkg::CHAR_BITS-1:0]      digit_char;
    logic                                last_digit;
    logic [u2rd_pkg::COUNT_BITS-1:0]     digit_count;

    modport source (output valid, output digit_char, output last_digit, output digit_count,
                    input ready);
    modport sink   (input valid, input digit_char, input last_digit, input digit_count,
                    output ready);
endinterface

>>> rtl/unsigned_to_radix_digits.sv
// top level of the unsigned value to radix digit string converter
//
//  channel  | dir | payload                                   | handshake
//  i_in     | in  | number[63:0], radix[5:0]                  | valid/ready
//  o_out    | out | digit_char[6:0], last_digit, digit_count  | valid/ready
//
// division makes 8 quotient bits per cycle, one digit per full pass over the 64-bit
// value; digits are read back most significant first through the registered digit store
// port, each read (ST_READ) followed by loading the output word (ST_LOAD)
// a two-entry queue lets new requests be taken while digits are still going out
// reset is synchronous and active low; the digit store is not cleared
// a stalled output holds its word and halts readout; the next division waits for readout to end
module unsigned_to_radix_digits (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u2rd_in_if.sink     i_in,
    u2rd_out_if.source  o_out
);
    import u2rd_pkg::*;

    t_push push;
    t_pop  pop;
    logic  q_full;
    logic  pop_ready;

    u2rd_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push)
    );

    u2rd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (q_full),
        .o_pop       (pop),
        .i_pop_ready (pop_ready)
    );

    u2rd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop       (pop),
        .o_pop_ready (pop_ready),
        .o_out       (o_out)
    );

endmodule

>>> rtl/u2rd_front.sv
// front end: takes request words, clamps the radix and trims the value
module u2rd_front (
    u2rd_in_if.sink          i_in,
    input  logic             i_q_full,
    output u2rd_pkg::t_push  o_push
);
    import u2rd_pkg::*;

    logic [RADIX_BITS-1:0] radix_fix;

    always_comb begin
        if (i_in.radix < RADIX_MIN) begin
            radix_fix = RADIX_MIN;
        end else if (i_in.radix > RADIX_MAX) begin
            radix_fix = RADIX_MAX;
        end else begin
            radix_fix = i_in.radix;
        end
    end

    assign i_in.ready         = !i_q_full;
    assign o_push.valid       = i_in.valid && !i_q_full;
    assign o_push.job.value   = i_in.number[VALUE_BITS-1:0];
    assign o_push.job.radix   = radix_fix;

endmodule

>>> rtl/u2rd_queue.sv
// two-entry job queue between front and back
module u2rd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  u2rd_pkg::t_push  i_push,
    output logic             o_full,
    output u2rd_pkg::t_pop   o_pop,
    input  logic             i_pop_ready
);
    import u2rd_pkg::*;

    t_job                      r_slot [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wptr, n_wptr;
    logic [QUEUE_PTR_BITS-1:0] r_rptr, n_rptr;
    logic [QUEUE_CNT_BITS-1:0] r_cnt, n_cnt;
    logic                      do_push, do_pop;

    assign o_full      = (r_cnt == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign o_pop.valid = (r_cnt != '0);
    assign o_pop.job   = r_slot[r_rptr];
    assign do_push     = i_push.valid && !o_full;
    assign do_pop      = o_pop.valid && i_pop_ready;

    always_comb begin
        n_wptr = do_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr = do_pop  ? r_rptr + 1'b1 : r_rptr;
        n_cnt  = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_push.job;
        end
    end

endmodule

>>> rtl/u2rd_back.sv
// back end: chunked long division into the digit store, then reverse readout
module u2rd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  u2rd_pkg::t_pop  i_pop,
    output logic            o_pop_ready,
    u2rd_out_if.source      o_out
);
    import u2rd_pkg::*;

    t_back_state           r_state, n_state;
    logic [DIV_BITS-1:0]   r_quo, n_quo;
    logic [RADIX_BITS-1:0] r_radix, n_radix;
    logic [RADIX_BITS-1:0] r_rem, n_rem;
    logic [CHUNK_BITS-1:0] r_chunk, n_chunk;
    logic [COUNT_BITS-1:0] r_n, n_n;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [ADDR_BITS-1:0]  r_idx, n_idx;
    logic                  r_out_valid, n_out_valid;
    logic [CHAR_BITS-1:0]  r_out_char, n_out_char;
    logic                  r_out_last, n_out_last;
    logic [COUNT_BITS-1:0] r_out_count, n_out_count;

    logic [CHAR_BITS-1:0]  r_store [STORE_DEPTH];
    logic [CHAR_BITS-1:0]  r_rd_data;
    logic                  mem_we;
    logic [CHAR_BITS-1:0]  mem_wdata;
    logic                  load_out;

    logic [RADIX_BITS-1:0] div_rem;
    logic [STEP_BITS-1:0]  div_q;
    logic [DIV_BITS-1:0]   div_quo;

    // one chunk of restoring division, msb first
    always_comb begin
        logic [RADIX_BITS:0]   trial;
        logic [RADIX_BITS-1:0] rem;
        logic [STEP_BITS-1:0]  top;
        top   = r_quo[DIV_BITS-1 -: STEP_BITS];
        rem   = r_rem;
        div_q = '0;
        for (int i = STEP_BITS - 1; i >= 0; i--) begin
            trial = {rem, top[i]};
            if (trial >= {1'b0, r_radix}) begin
                rem      = RADIX_BITS'(trial - {1'b0, r_radix});
                div_q[i] = 1'b1;
            end else begin
                rem = trial[RADIX_BITS-1:0];
            end
        end
        div_rem = rem;
        div_quo = (r_quo << STEP_BITS) | DIV_BITS'(div_q);
    end

    assign load_out = (r_state == ST_LOAD) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state     = r_state;
        n_quo       = r_quo;
        n_radix     = r_radix;
        n_rem       = r_rem;
        n_chunk     = r_chunk;
        n_n         = r_n;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_count = r_out_count;
        o_pop_ready = 1'b0;
        mem_we      = 1'b0;
        mem_wdata   = digit_to_ascii(div_rem);

        case (r_state)
            ST_IDLE: begin
                o_pop_ready = 1'b1;
                if (i_pop.valid) begin
                    n_quo   = DIV_BITS'(i_pop.job.value);
                    n_radix = i_pop.job.radix;
                    n_rem   = '0;
                    n_chunk = '0;
                    n_n     = '0;
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                n_quo = div_quo;
                n_rem = div_rem;
                if (r_chunk == CHUNK_BITS'(DIV_CHUNKS - 1)) begin
                    mem_we  = 1'b1;
                    n_rem   = '0;
                    n_chunk = '0;
                    n_n     = r_n + 1'b1;
                    if (div_quo == '0 || r_n == COUNT_BITS'(STORE_DEPTH - 1)) begin
                        n_idx   = r_n[ADDR_BITS-1:0];
                        n_count = r_n + 1'b1;
                        n_state = ST_READ;
                    end
                end else begin
                    n_chunk = r_chunk + 1'b1;
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                    n_out_char  = r_rd_data;
                    n_out_last  = (r_idx == '0);
                    n_out_count = r_count;
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo       <= n_quo;
        r_radix     <= n_radix;
        r_rem       <= n_rem;
        r_chunk     <= n_chunk;
        r_n         <= n_n;
        r_count     <= n_count;
        r_idx       <= n_idx;
        r_out_char  <= n_out_char;
        r_out_last  <= n_out_last;
        r_out_count <= n_out_count;
    end

    // digit store, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[r_n[ADDR_BITS-1:0]] <= mem_wdata;
        end
        r_rd_data <= r_store[r_idx];
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.digit_char  = r_out_char;
    assign o_out.last_digit  = r_out_last;
    assign o_out.digit_count = r_out_count;

    a_rem_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVIDE) |-> (r_rem < r_radix))
        else $error("partial remainder not below radix");

    a_radix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVIDE) |-> (r_radix >= RADIX_MIN && r_radix <= RADIX_MAX))
        else $error("radix out of range during divide");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_count != '0 && r_out_count <= COUNT_BITS'(STORE_DEPTH)))
        else $error("digit count out of range");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_idx == '0) |=> (r_state == ST_IDLE && r_out_last))
        else $error("last digit did not end the run");

endmodule

>>> tb/tb_top.sv
// testbench of the radix digit converter: random and directed values, checked digit by digit
`timescale 1ns / 100ps

module tb_top;
    import u2rd_pkg::*;

    localparam int CLK_HALF    = 2;
    localparam int RESET_CYCLES = 5;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 1000;
    localparam int RANDOM_ITEMS = 130;
    localparam int PHASES      = 3;
    localparam int MAX_REPORTS = 10;
    localparam int SEND_IDLE[PHASES] = '{18, 54, 0};
    localparam int RECV_IDLE[PHASES] = '{54, 18, 0};

    typedef struct {
        logic [NUMBER_BITS-1:0] number;
        logic [RADIX_BITS-1:0]  radix;
        logic                   hold;   // wait until every digit due has come out
        int                     phase;
    } t_request;

    typedef struct {
        logic [CHAR_BITS-1:0]  ch;
        logic                  last;
        logic [COUNT_BITS-1:0] count;
    } t_digit_word;

    logic i_clk;
    logic i_rst_n;

    u2rd_in_if  in_ch ();
    u2rd_out_if out_ch ();

    unsigned_to_radix_digits DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_request    requests_waiting[$];
    t_digit_word digits_due[$];
    int          mismatches;
    int          cur_phase;
    int          stall_cycles;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #CLK_HALF i_clk = ~i_clk;
    end

    // expected digits of one conversion, most significant first
    function void predict_digits(input logic [NUMBER_BITS-1:0] number,
                                 input logic [RADIX_BITS-1:0] radix_in);
        logic [NUMBER_BITS-1:0] quot;
        logic [CHAR_BITS-1:0]   found[STORE_DEPTH];
        int unsigned            base;
        int unsigned            rem;
        int                     n;
        t_digit_word            w;
        base = 32'(radix_in);
        if (base < 32'(RADIX_MIN)) base = 32'(RADIX_MIN);
        if (base > 32'(RADIX_MAX)) base = 32'(RADIX_MAX);
        quot = number & ({NUMBER_BITS{1'b1}} >> (NUMBER_BITS - VALUE_BITS));
        n = 0;
        do begin
            rem = 32'(quot % base);
            if (rem < 32'(DECIMAL_LIMIT)) begin
                found[n] = CHAR_ZERO + CHAR_BITS'(rem);
            end else begin
                found[n] = CHAR_LETTER_A + CHAR_BITS'(rem - 32'(DECIMAL_LIMIT));
            end
            n++;
            quot = quot / base;
        end while (quot != 0 && n < STORE_DEPTH);
        for (int k = n - 1; k >= 0; k--) begin
            w.ch    = found[k];
            w.last  = (k == 0);
            w.count = COUNT_BITS'(n);
            digits_due.push_back(w);
        end
    endfunction

    function void report_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    task automatic add_request(input logic [NUMBER_BITS-1:0] number,
                               input logic [RADIX_BITS-1:0] radix,
                               input logic hold, input int phase);
        t_request r;
        r.number = number;
        r.radix  = radix;
        r.hold   = hold;
        r.phase  = phase;
        requests_waiting.push_back(r);
    endtask

    // driver: one request word per handshake, idles at random and while a held request waits
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid  <= 1'b0;
            in_ch.number <= '0;
            in_ch.radix  <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) predict_digits(in_ch.number, in_ch.radix);
            if (!in_ch.valid || in_ch.ready) begin
                if (requests_waiting.size() == 0) begin
                    in_ch.valid <= 1'b0;
                end else if ($urandom_range(99) < SEND_IDLE[requests_waiting[0].phase]) begin
                    in_ch.valid <= 1'b0;
                end else if (requests_waiting[0].hold &&
                             (digits_due.size() != 0 || (in_ch.valid && in_ch.ready))) begin
                    in_ch.valid <= 1'b0;
                end else begin
                    t_request r;
                    r = requests_waiting.pop_front();
                    in_ch.valid  <= 1'b1;
                    in_ch.number <= r.number;
                    in_ch.radix  <= r.radix;
                    cur_phase    <= r.phase;
                end
            end
        end
    end

    // monitor: compares each digit word with the oldest one due
    always @(posedge i_clk) begin : digit_check
        t_digit_word want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (digits_due.size() == 0) begin
                    report_error($sformatf("unexpected word char=%0d last=%0b count=%0d",
                                           out_ch.digit_char, out_ch.last_digit,
                                           out_ch.digit_count));
                end else begin
                    want = digits_due.pop_front();
                    if (out_ch.digit_char !== want.ch || out_ch.last_digit !== want.last ||
                        out_ch.digit_count !== want.count) begin
                        report_error($sformatf(
                            "char %0d/%0d last %0b/%0b count %0d/%0d (expected/actual)",
                            want.ch, out_ch.digit_char, want.last, out_ch.last_digit,
                            want.count, out_ch.digit_count));
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= RECV_IDLE[cur_phase]);
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [NUMBER_BITS-1:0] num;
        logic [RADIX_BITS-1:0]  rdx;
        int                     kind;
        mismatches   = 0;
        cur_phase    = 0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.number = '0;
        in_ch.radix  = '0;
        out_ch.ready = 1'b0;

        // directed: extremes, clamped bases, zero, letter digits
        add_request(64'd0, 6'd10, 1'b0, 0);
        add_request('1, 6'd2, 1'b0, 0);
        add_request('1, 6'd36, 1'b0, 0);
        add_request('1, 6'd16, 1'b0, 0);
        add_request('1, 6'd10, 1'b0, 0);
        add_request(64'd255, 6'd0, 1'b0, 0);
        add_request(64'd255, 6'd1, 1'b1, 0);
        add_request(64'd1295, 6'd37, 1'b0, 0);
        add_request('1, 6'd63, 1'b0, 0);
        add_request(64'd0, 6'd63, 1'b0, 0);
        add_request(64'd0, 6'd0, 1'b0, 0);
        add_request(64'd35, 6'd36, 1'b0, 0);
        add_request(64'd10, 6'd11, 1'b0, 0);
        add_request(64'd36, 6'd36, 1'b0, 0);
        add_request(64'd1, 6'd2, 1'b0, 0);
        add_request(64'h8000_0000_0000_0000, 6'd2, 1'b0, 0);
        add_request(64'd100, 6'd10, 1'b0, 0);
        add_request(64'h0123_4567_89AB_CDEF, 6'd16, 1'b1, 0);
        add_request(64'hAAAA_AAAA_AAAA_AAAA, 6'd3, 1'b0, 0);
        add_request(64'h5555_5555_5555_5555, 6'd35, 1'b0, 0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            kind = $urandom_range(3);
            case (kind)
                0: num = {$urandom, $urandom};
                1: num = NUMBER_BITS'($urandom_range(0, 1000));
                2: num = {$urandom, $urandom} >> $urandom_range(63);
                default: begin
                    case ($urandom_range(2))
                        0: num = '1;
                        1: num = '0;
                        default: num = 64'd1 << $urandom_range(63);
                    endcase
                end
            endcase
            if ($urandom_range(9) == 0) rdx = RADIX_BITS'($urandom_range(63));
            else rdx = RADIX_BITS'($urandom_range(RADIX_MIN, RADIX_MAX));
            add_request(num, rdx, (i % 50 == 0) || ($urandom_range(24) == 0),
                        i * PHASES / RANDOM_ITEMS);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_waiting.size() != 0 || in_ch.valid) @(posedge i_clk);
        while (digits_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && digits_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
